### hw/rtl/bad_pkg.sv
// Shared types, constants and register codes of the block average downsampler.
package bad_pkg;

  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_CHUNK = 64;
  localparam int MAX_HEIGHT    = 4096;

  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DIM_W      = 13;
  localparam int CHUNK_W    = 7;
  localparam int COORD_W    = 12;
  localparam int COLOR_W    = 8;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [CHUNK_W-1:0] RST_TILE_SIDE    = 7'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_TILE_SIDE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               start_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] chunk_col;
    logic [COORD_W-1:0] chunk_row;
    logic [COLOR_W-1:0] avg_red;
    logic [COLOR_W-1:0] avg_green;
    logic [COLOR_W-1:0] avg_blue;
    logic               last_of_frame;
  } result_t;

endpackage

### hw/rtl/bad_stream_if.sv
// Valid/ready channel interfaces for pixels in and chunk averages out.
interface bad_pix_if import bad_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bad_res_if import bad_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bad_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/bad_div.sv
// Iterative restoring divider, one quotient bit per cycle, three channels at once.
module bad_div import bad_pkg::*; #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend [3],
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [COLOR_W-1:0] quotient [3]
);

  localparam int IT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] num_r [3];
  logic [SUM_W-1:0] num_nxt [3];
  logic [CNT_W:0]   rem_r [3];
  logic [CNT_W:0]   rem_nxt [3];
  logic [CNT_W-1:0] den_r;
  logic [IT_W-1:0]  iter_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    logic [CNT_W:0] trial;
    for (int c = 0; c < 3; c++) begin
      trial = {rem_r[c][CNT_W-1:0], num_r[c][SUM_W-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt[c] = trial - {1'b0, den_r};
        num_nxt[c] = {num_r[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = trial;
        num_nxt[c] = {num_r[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        if (iter_r == IT_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        iter_r <= iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= '0;
      end
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  // After the last step the dividend register has become the quotient.
  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quotient[c] = num_r[c][COLOR_W-1:0];
    end
  end

endmodule

### hw/rtl/block_average_downsampler.sv
// Top level of the block average downsampler: counters, sum memory and sequencing.
//
// The block takes RGB pixels in raster order, tiles the image into square chunks whose
// side is the configured tile side (edge chunks cropped) and, when a chunk's last pixel
// arrives, emits the chunk's column and row and the floor of the mean of each color over
// the chunk. One running sum per chunk column is kept in a synchronous RAM of MAX_WIDTH
// entries; the first pixel of a chunk overwrites its entry, which clears the band's sums.
// The sum of a pixel is read in the accept cycle and written back in the next. A pixel
// that finishes a chunk then starts the shared divider, waits for its done and has its
// result loaded into the output register before the next pixel is accepted, later if
// the previous result is still waiting. The output register lets the next pixel be
// accepted while a result waits to be taken. After reset the block zeroes the sum RAM
// before it accepts its first pixel; configuration writes are taken at any time.
module block_average_downsampler import bad_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_CHUNK = DEF_MAX_CHUNK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bad_pix_if.sink               in_pix,
  bad_res_if.source             out_res
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int OW    = $clog2(MAX_CHUNK);
  localparam int LW    = $clog2(MAX_CHUNK + 1);
  localparam int CNT_W = 2 * LW;
  localparam int SUM_W = COLOR_W + CNT_W;
  localparam int WCW   = ((XW + 1) > DIM_W) ? (XW + 1) : DIM_W;
  localparam int CSW   = (LW > CHUNK_W) ? LW : CHUNK_W;
  localparam int YW    = $clog2(MAX_HEIGHT);

  // Configuration registers.
  logic [DIM_W-1:0]   image_width_r;
  logic [DIM_W-1:0]   image_height_r;
  logic [CHUNK_W-1:0] tile_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      tile_side_r    <= RST_TILE_SIDE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        CFG_TILE_SIDE:    tile_side_r    <= cfg_data[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective bounds, clamped to the range the storage supports.
  logic [WCW-1:0]   w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [CSW-1:0]   cs_eff;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WCW'(1);
    end else if (WCW'(image_width_r) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    if (tile_side_r == '0) begin
      cs_eff = CSW'(1);
    end else if (CSW'(tile_side_r) > CSW'(MAX_CHUNK)) begin
      cs_eff = CSW'(MAX_CHUNK);
    end else begin
      cs_eff = CSW'(tile_side_r);
    end
  end

  // Position counters and sequencing state.
  state_t          state_r, state_nxt;
  logic [XW-1:0]   px_r, px_nxt;
  logic [YW-1:0]   py_r, py_nxt;
  logic [OW-1:0]   ox_r, ox_nxt;
  logic [OW-1:0]   oy_r, oy_nxt;
  logic [XW-1:0]   ccol_r, ccol_nxt;
  logic [YW-1:0]   crow_r, crow_nxt;
  logic [XW-1:0]   clr_r;
  pixel_t          pix_r;

  logic [COORD_W-1:0] res_col_r, res_row_r;
  logic               res_last_r;
  logic [CNT_W-1:0]   count_r;

  logic               accept;
  logic               ram_we;
  logic [XW-1:0]      ram_waddr;
  logic [3*SUM_W-1:0] ram_wdata;
  logic [XW-1:0]      ram_raddr;
  logic [3*SUM_W-1:0] ram_rdata;

  logic [SUM_W-1:0]   sum_new [3];
  logic [SUM_W-1:0]   div_in [3];
  logic [COLOR_W-1:0] div_q [3];
  logic               div_start;
  logic               div_done;

  logic row_end, col_end, chunk_end_x, band_end, chunk_done;
  logic out_load;
  logic out_valid_r;

  assign accept        = in_pix.valid && in_pix.ready;
  assign in_pix.ready  = (state_r == ST_IDLE);

  // A start of frame zeroes the column index before the read is issued.
  assign ram_raddr = in_pix.data.start_of_frame ? '0 : ccol_r;

  assign row_end     = (WCW'(px_r) + WCW'(1)) >= w_eff;
  assign col_end     = (DIM_W'(py_r) + DIM_W'(1)) >= h_eff;
  assign chunk_end_x = row_end || ((CSW'(ox_r) + CSW'(1)) >= cs_eff);
  assign band_end    = col_end || ((CSW'(oy_r) + CSW'(1)) >= cs_eff);
  assign chunk_done  = chunk_end_x && band_end;

  // Accumulate: the first pixel of a chunk replaces the stored sum.
  always_comb begin
    logic first;
    first = (ox_r == '0) && (oy_r == '0);
    sum_new[0] = (first ? '0 : ram_rdata[3*SUM_W-1:2*SUM_W]) + SUM_W'(pix_r.red);
    sum_new[1] = (first ? '0 : ram_rdata[2*SUM_W-1:SUM_W])   + SUM_W'(pix_r.green);
    sum_new[2] = (first ? '0 : ram_rdata[SUM_W-1:0])         + SUM_W'(pix_r.blue);
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = (state_r == ST_ACC);
      ram_waddr = ccol_r;
      ram_wdata = {sum_new[0], sum_new[1], sum_new[2]};
    end
  end

  bad_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sums for the divider are captured as they are written back.
  logic [SUM_W-1:0] div_sum_r [3];

  always_ff @(posedge clk) begin
    if (state_r == ST_ACC && chunk_done) begin
      div_sum_r  <= sum_new;
      count_r    <= (CNT_W'(ox_r) + CNT_W'(1)) * (CNT_W'(oy_r) + CNT_W'(1));
      res_col_r  <= COORD_W'(ccol_r);
      res_row_r  <= COORD_W'(crow_r);
      res_last_r <= row_end && col_end;
    end
    if (accept) begin
      pix_r <= in_pix.data;
    end
  end

  // The product is registered in the accumulate cycle and enters the divider in the next.
  logic div_go_r;
  assign div_start = div_go_r;
  assign div_in    = div_sum_r;

  bad_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_res.ready);

  // Next state and counter updates.
  always_comb begin
    state_nxt = state_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    ccol_nxt  = ccol_r;
    crow_nxt  = crow_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ACC;
          if (in_pix.data.start_of_frame) begin
            px_nxt   = '0;
            py_nxt   = '0;
            ox_nxt   = '0;
            oy_nxt   = '0;
            ccol_nxt = '0;
            crow_nxt = '0;
          end
        end
      end
      ST_ACC: begin
        state_nxt = chunk_done ? ST_DIV : ST_IDLE;
        if (row_end) begin
          px_nxt   = '0;
          ox_nxt   = '0;
          ccol_nxt = '0;
          if (col_end) begin
            py_nxt   = '0;
            oy_nxt   = '0;
            crow_nxt = '0;
          end else begin
            py_nxt = py_r + 1'b1;
            if (band_end) begin
              oy_nxt   = '0;
              crow_nxt = crow_r + 1'b1;
            end else begin
              oy_nxt = oy_r + 1'b1;
            end
          end
        end else begin
          px_nxt = px_r + 1'b1;
          if (chunk_end_x) begin
            ox_nxt   = '0;
            ccol_nxt = ccol_r + 1'b1;
          end else begin
            ox_nxt = ox_r + 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      px_r     <= '0;
      py_r     <= '0;
      ox_r     <= '0;
      oy_r     <= '0;
      ccol_r   <= '0;
      crow_r   <= '0;
      div_go_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      px_r     <= px_nxt;
      py_r     <= py_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      ccol_r   <= ccol_nxt;
      crow_r   <= crow_nxt;
      div_go_r <= (state_r == ST_ACC) && chunk_done;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  // Output register: holds one finished result until the sink takes it.
  result_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.chunk_col     <= res_col_r;
      out_data_r.chunk_row     <= res_row_r;
      out_data_r.avg_red       <= div_q[0];
      out_data_r.avg_green     <= div_q[1];
      out_data_r.avg_blue      <= div_q[2];
      out_data_r.last_of_frame <= res_last_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = out_data_r;

  // The accumulate cycle always follows an accepted transaction.
  a_acc_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> $past(accept))
    else $error("accumulate cycle without an accepted transaction");

  // No pixel is taken while the sum memory is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_pix.ready)
    else $error("input ready during memory clear");

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_res.ready))
    else $error("output register overwritten");

  // The divider is started in the cycle right after a chunk-finishing accumulate.
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == ST_DIV) && $past(state_r == ST_ACC))
    else $error("divider started outside a chunk end");

endmodule
